>>> hw/rtl/hmq_pkg.sv
// ----------------------------------------------------------------------------
// hmq_pkg
// Shared types, widths and command codes for the binary max-heap queue.
// ----------------------------------------------------------------------------
package hmq_pkg;

  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 16;
  localparam int KEY_W        = 32;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int CHILD_W      = ADDR_W + 2;
  localparam int ENTRY_W      = KEY_W + PAYLOAD_BITS;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] pay;
    logic [KEY_W-1:0]        key;
  } hmq_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture a new request
    logic ins_begin;  // open a hole at the end of the heap
    logic rd_parent;  // read the parent of the hole
    logic rd_child;   // read both children of the hole
    logic rd_top;     // read root and last entry
    logic take_top;   // capture root as result, last entry as mover
    logic up_move;    // pull the parent down into the hole
    logic dn_move;    // pull the larger child up into the hole
    logic wr_hole;    // park the mover in the hole
    logic out_load;   // load the result register
  } hmq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       cnt_zero;
    logic       cnt_full;
    logic       cnt_one;
    logic       pos_zero;
    logic       has_child;
    logic       up_go;
    logic       dn_go;
  } hmq_stat_t;

endpackage

>>> hw/rtl/hmq_ram.sv
// ----------------------------------------------------------------------------
// hmq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hw/rtl/hmq_datapath.sv
// ----------------------------------------------------------------------------
// hmq_datapath
// Heap storage, hole position, entry count, mover entry and result register.
// ----------------------------------------------------------------------------
module hmq_datapath import hmq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  hmq_cmd_t                cmd,
  output hmq_stat_t               stat,
  input  logic [1:0]              in_cmd,
  input  logic [KEY_W-1:0]        in_key,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  output logic [KEY_W-1:0]        out_key,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic                    was_empty,
  output logic                    was_full,
  output logic [CNT_W-1:0]        fill_count
);

  logic [1:0]              cmd_r;
  logic [CNT_W-1:0]        count;
  logic [ADDR_W-1:0]       pos;
  hmq_entry_t              mover;
  logic [KEY_W-1:0]        res_key;
  logic [PAYLOAD_BITS-1:0] res_pay;
  logic                    res_empty;
  logic                    res_full;

  hmq_entry_t              rd_a;
  hmq_entry_t              rd_b;
  logic [ENTRY_W-1:0]      rdata_a;
  logic [ENTRY_W-1:0]      rdata_b;
  logic [ADDR_W-1:0]       raddr_a;
  logic [ADDR_W-1:0]       raddr_b;
  logic                    we;
  hmq_entry_t              wdata;

  logic [ADDR_W-1:0]       parent;
  logic [CHILD_W-1:0]      lc;
  logic [CHILD_W-1:0]      rc;
  logic [CHILD_W-1:0]      count_ext;
  logic                    lc_ok;
  logic                    rc_ok;
  logic                    pick_l;
  logic                    pick_r;
  logic [KEY_W-1:0]        best_key;
  hmq_entry_t              best_ent;
  logic [ADDR_W-1:0]       best_idx;
  logic                    in_read;
  logic                    cnt_zero;
  logic                    cnt_full;

  assign parent    = ADDR_W'((pos - 1'b1) >> 1);
  assign lc        = {1'b0, pos, 1'b1};
  assign rc        = lc + 1'b1;
  assign count_ext = CHILD_W'(count);
  assign lc_ok     = lc < count_ext;
  assign rc_ok     = rc < count_ext;
  assign cnt_zero  = count == '0;
  assign cnt_full  = count == CNT_W'(CAPACITY);
  assign rd_a      = hmq_entry_t'(rdata_a);
  assign rd_b      = hmq_entry_t'(rdata_b);

  // larger of mover, left child and right child; ties keep the earlier one
  always_comb begin
    pick_l   = lc_ok && (rd_a.key > mover.key);
    best_key = pick_l ? rd_a.key : mover.key;
    pick_r   = rc_ok && (rd_b.key > best_key);
    best_ent = pick_r ? rd_b : rd_a;
    best_idx = pick_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
  end

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd.rd_parent) begin
      raddr_a = parent;
    end else if (cmd.rd_child) begin
      raddr_a = lc[ADDR_W-1:0];
      raddr_b = rc[ADDR_W-1:0];
    end else if (cmd.rd_top) begin
      raddr_b = ADDR_W'(count - 1'b1);
    end
  end

  always_comb begin
    we    = cmd.wr_hole || cmd.up_move || cmd.dn_move;
    wdata = mover;
    if (cmd.up_move) begin
      wdata = rd_a;
    end else if (cmd.dn_move) begin
      wdata = best_ent;
    end
  end

  hmq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (pos),
    .wdata   (ENTRY_W'(wdata)),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign in_read = (in_cmd == CMD_EXTRACT) || (in_cmd == CMD_PEEK);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_begin) begin
      count <= count + 1'b1;
    end else if (cmd.take_top && (cmd_r == CMD_EXTRACT)) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r       <= in_cmd;
      mover.key   <= in_key;
      mover.pay   <= in_payload;
      res_key     <= (in_read && cnt_zero) ? '1 : '0;
      res_pay     <= '0;
      res_empty   <= in_read && cnt_zero;
      res_full    <= (in_cmd == CMD_INSERT) && cnt_full;
    end
    if (cmd.ins_begin) begin
      pos <= count[ADDR_W-1:0];
    end else if (cmd.up_move) begin
      pos <= parent;
    end else if (cmd.dn_move) begin
      pos <= best_idx;
    end else if (cmd.take_top) begin
      pos <= '0;
    end
    if (cmd.take_top) begin
      res_key <= rd_a.key;
      res_pay <= rd_a.pay;
      mover   <= rd_b;
    end
    if (cmd.out_load) begin
      out_key     <= res_key;
      out_payload <= res_pay;
      was_empty   <= res_empty;
      was_full    <= res_full;
      fill_count  <= count;
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.cnt_zero  = cnt_zero;
  assign stat.cnt_full  = cnt_full;
  assign stat.cnt_one   = count == CNT_W'(1);
  assign stat.pos_zero  = pos == '0;
  assign stat.has_child = lc_ok;
  assign stat.up_go     = rd_a.key < mover.key;
  assign stat.dn_go     = pick_l || pick_r;

endmodule

>>> hw/rtl/hmq_ctrl.sv
// ----------------------------------------------------------------------------
// hmq_ctrl
// Sequencer for insert, extract, peek and idle commands; owns the request ready and result valid.
// ----------------------------------------------------------------------------
module hmq_ctrl import hmq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  hmq_stat_t stat,
  output hmq_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_UP_RD  = 4'd2;
  localparam logic [3:0] S_UP_CMP = 4'd3;
  localparam logic [3:0] S_TOP    = 4'd4;
  localparam logic [3:0] S_DN_RD  = 4'd5;
  localparam logic [3:0] S_DN_CMP = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        case (stat.cmd)
          CMD_INSERT: begin
            if (stat.cnt_full) begin
              state_next = S_OUT;
            end else begin
              cmd.ins_begin = 1'b1;
              state_next    = S_UP_RD;
            end
          end
          CMD_EXTRACT, CMD_PEEK: begin
            if (stat.cnt_zero) begin
              state_next = S_OUT;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_TOP;
            end
          end
          default: state_next = S_OUT;
        endcase
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_hole = 1'b1;
          state_next  = S_OUT;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_go) begin
          cmd.up_move = 1'b1;
          state_next  = S_UP_RD;
        end else begin
          cmd.wr_hole = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_TOP: begin
        cmd.take_top = 1'b1;
        // a single entry leaves nothing to sift
        if (stat.cmd == CMD_EXTRACT && !stat.cnt_one) begin
          state_next = S_DN_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DN_RD: begin
        if (stat.has_child) begin
          cmd.rd_child = 1'b1;
          state_next   = S_DN_CMP;
        end else begin
          cmd.wr_hole = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_go) begin
          cmd.dn_move = 1'b1;
          state_next  = S_DN_RD;
        end else begin
          cmd.wr_hole = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hw/rtl/binary_max_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit
// A dropped insert, an empty read, an idle command or a peek walks no heap level;
// an insert sifts up and an extract sifts down, one level at a time.
// Each heap level walked takes a store read, then a compare and write.
// The next request is taken in the cycle after the result is registered.
// Reset clears the entry count, control state and result valid; heap storage is kept.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_unit import hmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // in_key[31:0], in_payload[47:32]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_key[31:0], out_payload[47:32], fill_count[54:48], 0
  output logic [1:0]  m_tuser    // was_empty[0], was_full[1]
);

  hmq_cmd_t                cmd;
  hmq_stat_t               stat;
  logic [KEY_W-1:0]        out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    was_empty;
  logic                    was_full;
  logic [CNT_W-1:0]        fill_count;

  hmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hmq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_cmd      (s_tuser),
    .in_key      (s_tdata[31:0]),
    .in_payload  (s_tdata[47:32]),
    .out_key     (out_key),
    .out_payload (out_payload),
    .was_empty   (was_empty),
    .was_full    (was_full),
    .fill_count  (fill_count)
  );

  assign m_tdata = {1'b0, fill_count, out_payload, out_key};
  assign m_tuser = {was_full, was_empty};

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fill_count <= CNT_W'(CAPACITY)))
    else $error("fill count above capacity");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(was_empty && was_full))
    else $error("empty and full flagged together");

  a_empty_key: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && was_empty) |-> (out_key == '1) && (fill_count == '0))
    else $error("empty result with bad key or count");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in progress");

endmodule

>>> dv/hmq_heap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmq_heap_checker
// Passive checker for the heap queue: tracks its own copy of the heap from
// accepted requests, predicts one result per request and compares each
// delivered result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hmq_heap_checker import hmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // in_key[31:0], in_payload[47:32]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // out_key[31:0], out_payload[47:32], fill_count[54:48], 0
  input  logic [1:0]  m_tuser,   // was_empty[0], was_full[1]
  output int          failures,
  output int          pending,
  output int          checked,
  output int          full_hits,
  output int          empty_hits
);

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] pay;
    logic                    empty;
    logic                    full;
    logic [CNT_W-1:0]        fill;
  } heap_result_t;

  logic [KEY_W-1:0]        heap_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] heap_pay [CAPACITY];
  int unsigned             heap_size;

  heap_result_t due_results[$];
  heap_result_t want;

  function automatic void exchange_entries(int unsigned a, int unsigned b);
    logic [KEY_W-1:0]        k;
    logic [PAYLOAD_BITS-1:0] p;
    k = heap_key[a];
    p = heap_pay[a];
    heap_key[a] = heap_key[b];
    heap_pay[a] = heap_pay[b];
    heap_key[b] = k;
    heap_pay[b] = p;
  endfunction

  // Apply one request to the shadow heap and return the result it should produce.
  function automatic heap_result_t apply_request(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                                 logic [PAYLOAD_BITS-1:0] pay);
    heap_result_t r;
    int unsigned  hole, up, best, lc, rc;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (heap_size >= CAPACITY) begin
          r.full = 1'b1;
        end else begin
          hole = heap_size;
          heap_key[hole] = key;
          heap_pay[hole] = pay;
          heap_size++;
          // climb only while the parent is strictly smaller
          while (hole > 0) begin
            up = (hole - 1) / 2;
            if (!(heap_key[up] < heap_key[hole])) break;
            exchange_entries(up, hole);
            hole = up;
          end
        end
      end
      CMD_EXTRACT, CMD_PEEK: begin
        if (heap_size == 0) begin
          r.key   = '1;
          r.empty = 1'b1;
        end else begin
          r.key = heap_key[0];
          r.pay = heap_pay[0];
          if (cmd == CMD_EXTRACT) begin
            heap_size--;
            heap_key[0] = heap_key[heap_size];
            heap_pay[0] = heap_pay[heap_size];
            hole = 0;
            // ties keep the parent, and the left child wins between equal children
            while (1) begin
              best = hole;
              lc   = 2 * hole + 1;
              rc   = lc + 1;
              if (lc < heap_size && heap_key[lc] > heap_key[best]) best = lc;
              if (rc < heap_size && heap_key[rc] > heap_key[best]) best = rc;
              if (best == hole) break;
              exchange_entries(hole, best);
              hole = best;
            end
          end
        end
      end
      default: ;
    endcase
    r.fill = heap_size[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] expected,
                             input logic [63:0] actual);
    if (expected !== actual) begin
      failures++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      heap_size  = 0;
      due_results.delete();
      failures   = 0;
      checked    = 0;
      full_hits  = 0;
      empty_hits = 0;
    end else begin
      if (s_tvalid && s_tready)
        due_results.push_back(apply_request(s_tuser, s_tdata[31:0], s_tdata[47:32]));
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          failures++;
          $error("result with no request outstanding: tdata 0x%0h tuser 0x%0h",
                 m_tdata, m_tuser);
        end else begin
          want = due_results.pop_front();
          check_field("out_key",     64'(want.key),   64'(m_tdata[31:0]));
          check_field("out_payload", 64'(want.pay),   64'(m_tdata[47:32]));
          check_field("fill_count",  64'(want.fill),  64'(m_tdata[54:48]));
          check_field("tdata pad",   64'(1'b0),       64'(m_tdata[55]));
          check_field("was_empty",   64'(want.empty), 64'(m_tuser[0]));
          check_field("was_full",    64'(want.full),  64'(m_tuser[1]));
          checked++;
          if (want.full)  full_hits++;
          if (want.empty) empty_hits++;
        end
      end
    end
    pending = due_results.size();
  end

endmodule

>>> dv/binary_max_heap_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit_tb
// Drives insert, extract, peek and idle commands into the heap queue with
// random gaps and back-pressure; a separate checker predicts every result.
// Directed cases cover the empty and tie corners, then random phases fill the
// store past full, drain it past empty and mix the commands.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_unit_tb;
  import hmq_pkg::*;

  localparam int RANDOM_REQUESTS = 400;
  localparam int CYCLE_LIMIT     = 200000;

  typedef enum {FILL_UP, DRAIN_DOWN, MIXED} traffic_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = CMD_NOP;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  logic no_gaps = 1'b0;
  int   cycle_count = 0;
  int   sent_insert = 0, sent_extract = 0, sent_peek = 0, sent_nop = 0;
  int   failures, pending, checked, full_hits, empty_hits;

  binary_max_heap_queue_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  hmq_heap_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .failures   (failures),
    .pending    (pending),
    .checked    (checked),
    .full_hits  (full_hits),
    .empty_hits (empty_hits)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // stall the result side now and then, except during the steady stretch
  always @(negedge clk)
    m_tready <= no_gaps || ($urandom_range(0, 99) >= 20);

  task automatic push_request(input logic [1:0] cmd, input logic [31:0] key,
                              input logic [15:0] pay);
    @(negedge clk);
    if (!no_gaps && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {pay, key};
    case (cmd)
      CMD_INSERT:  sent_insert++;
      CMD_EXTRACT: sent_extract++;
      CMD_PEEK:    sent_peek++;
      default:     sent_nop++;
    endcase
    do @(posedge clk); while (!s_tready);
  endtask

  // small keys force ties, the rest spread over the whole range
  function automatic logic [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return $urandom_range(0, 7);
    if (roll < 35) return 32'h0;
    if (roll < 40) return 32'hFFFF_FFFF;
    if (roll < 45) return 32'hFFFF_FFF8 | $urandom_range(0, 7);
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_cmd(traffic_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      FILL_UP:    return (roll < 95) ? CMD_INSERT : CMD_PEEK;
      DRAIN_DOWN: begin
        if (roll < 85) return CMD_EXTRACT;
        if (roll < 95) return CMD_PEEK;
        return CMD_INSERT;
      end
      default: begin
        if (roll < 45) return CMD_INSERT;
        if (roll < 75) return CMD_EXTRACT;
        if (roll < 95) return CMD_PEEK;
        return CMD_NOP;
      end
    endcase
  endfunction

  initial begin
    traffic_mode_t mode;
    int            sent;
    int            phase;
    int            phase_len;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty queue, extremes, equal keys and the left-child tie on extract
    push_request(CMD_PEEK,    32'h0,         16'h0);
    push_request(CMD_EXTRACT, 32'hFFFF_FFFF, 16'hFFFF);
    push_request(CMD_NOP,     32'hFFFF_FFFF, 16'hFFFF);
    push_request(CMD_INSERT,  32'h0,         16'h0);
    push_request(CMD_INSERT,  32'hFFFF_FFFF, 16'hFFFF);
    push_request(CMD_INSERT,  32'h5,         16'h0001);
    push_request(CMD_INSERT,  32'h5,         16'h0002);
    push_request(CMD_INSERT,  32'h5,         16'h0003);
    push_request(CMD_PEEK,    32'h0,         16'h0);
    push_request(CMD_EXTRACT, 32'h0,         16'h0);
    push_request(CMD_EXTRACT, 32'h0,         16'h0);
    push_request(CMD_NOP,     $urandom,      16'($urandom));
    push_request(CMD_EXTRACT, 32'h0,         16'h0);
    push_request(CMD_EXTRACT, 32'h0,         16'h0);
    push_request(CMD_EXTRACT, 32'h0,         16'h0);
    push_request(CMD_EXTRACT, 32'h0,         16'h0);
    push_request(CMD_INSERT,  32'hAAAA_AAAA, 16'h5555);
    push_request(CMD_INSERT,  32'h5555_5555, 16'hAAAA);
    push_request(CMD_PEEK,    32'h0,         16'h0);
    push_request(CMD_EXTRACT, 32'h0,         16'h0);
    push_request(CMD_EXTRACT, 32'h0,         16'h0);

    // fill past full first, drain past empty next, then random phases
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (phase == 0) begin
        mode = FILL_UP;
        phase_len = 90;
      end else if (phase == 1) begin
        mode = DRAIN_DOWN;
        phase_len = 90;
      end else begin
        mode = traffic_mode_t'($urandom_range(0, 2));
        phase_len = $urandom_range(20, 60);
      end
      repeat (phase_len) begin
        no_gaps = (sent >= 200 && sent < 280);
        push_request(pick_cmd(mode), pick_key(), 16'($urandom));
        sent++;
      end
      phase++;
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    no_gaps = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d inserts, %0d extracts, %0d peeks, %0d idle commands; %0d results checked.",
             sent_insert, sent_extract, sent_peek, sent_nop, checked);
    $display("Inserts dropped on a full store: %0d, reads of an empty queue: %0d.",
             full_hits, empty_hits);
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/hmq_pkg.sv
hw/rtl/hmq_ram.sv
hw/rtl/hmq_datapath.sv
hw/rtl/hmq_ctrl.sv
hw/rtl/binary_max_heap_queue_unit.sv
dv/hmq_heap_checker.sv
dv/binary_max_heap_queue_unit_tb.sv
